FILE: hw/rtl/trsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trsm_pkg;

   // Fixed field widths of the command and result beats
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int CHAN_W      = 2;
   localparam int FIELD_W     = 32;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MINMAX    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RD_START  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RD_NEXT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_DONE  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 2'd1;

   // Controls shared by all lanes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic acc_en;
      logic acc_first;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/trsm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module trsm_lane #(
   parameter int DEPTH      = 256,
   parameter int AW         = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire                                 clock,
   input  wire trsm_pkg::lane_ctrl_type        ctrl,
   input  wire        [AW-1:0]                 wr_addr,
   input  wire signed [VALUE_BITS-1:0]         wr_value,
   input  wire        [AW-1:0]                 rd_addr,
   output logic signed [VALUE_BITS-1:0]        rd_value,
   output logic signed [VALUE_BITS-1:0]        low_value,
   output logic signed [VALUE_BITS-1:0]        high_value
);

   logic signed [VALUE_BITS-1:0] mem_ff [DEPTH];
   logic signed [VALUE_BITS-1:0] rd_value_ff;
   logic signed [VALUE_BITS-1:0] low_ff;
   logic signed [VALUE_BITS-1:0] high_ff;

   // Write one channel value of a pushed sample
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_value;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_value_ff <= mem_ff[rd_addr];
      end
   end

   // Fold each read beat into the running minimum and maximum
   always_ff @(posedge clock) begin
      if (ctrl.acc_en) begin
         if (ctrl.acc_first) begin
            low_ff  <= rd_value_ff;
            high_ff <= rd_value_ff;
         end else begin
            if (rd_value_ff < low_ff) begin
               low_ff <= rd_value_ff;
            end
            if (rd_value_ff > high_ff) begin
               high_ff <= rd_value_ff;
            end
         end
      end
   end

   assign rd_value   = rd_value_ff;
   assign low_value  = low_ff;
   assign high_value = high_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/timed_sample_ring_minmax_core.sv
// Channel   Ports                                   Direction  Handshake
// request   req_command, req_value_0..3,            in         start / busy
//           req_sample_time
// response  rsp_status, rsp_channel, rsp_low_value,  out        rsp_strobe, one cycle
//           rsp_high_value, rsp_stamp,
//           rsp_stored_count, rsp_last_of_run
// csr       csr_index, csr_data                     in         csr_write
//
// Push, clear, count, start readout and any command that answers with a single
// beat leave the core idle, so the next command may start in the following cycle.
// Minmax holds busy through the scan, wait and merge states: the ring is walked
// one entry a cycle through the read port of each lane memory, then one result
// beat per channel leaves the merge stage. Read next holds busy while one sample
// beat per channel leaves. Result beats are registered.
// Reset empties the ring; a register write empties it as well.
// The receiver cannot stall: every beat is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module timed_sample_ring_minmax_core #(
   parameter int MAX_DEPTH    = 256,
   parameter int MAX_CHANNELS = 4,
   parameter int VALUE_BITS   = 32
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        start,
   output logic                                       busy,
   input  wire        [trsm_pkg::CMD_W-1:0]           req_command,
   input  wire signed [trsm_pkg::FIELD_W-1:0]         req_value_0,
   input  wire signed [trsm_pkg::FIELD_W-1:0]         req_value_1,
   input  wire signed [trsm_pkg::FIELD_W-1:0]         req_value_2,
   input  wire signed [trsm_pkg::FIELD_W-1:0]         req_value_3,
   input  wire        [trsm_pkg::FIELD_W-1:0]         req_sample_time,
   output logic                                       rsp_strobe,
   output logic       [trsm_pkg::STATUS_W-1:0]        rsp_status,
   output logic       [trsm_pkg::CHAN_W-1:0]          rsp_channel,
   output logic signed [trsm_pkg::FIELD_W-1:0]        rsp_low_value,
   output logic signed [trsm_pkg::FIELD_W-1:0]        rsp_high_value,
   output logic       [trsm_pkg::FIELD_W-1:0]         rsp_stamp,
   output logic       [trsm_pkg::COUNT_W-1:0]         rsp_stored_count,
   output logic                                       rsp_last_of_run,
   input  wire                                        csr_write,
   input  wire        [trsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire        [trsm_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW        = $clog2(MAX_DEPTH);
   localparam int CW        = $clog2(MAX_DEPTH + 1);
   localparam int XW        = CW + 1;
   localparam int IW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CAP_RESET = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_MM_OUT,
      ST_RD_OUT
   } state_type;

   state_type state_ff;

   // Ring bookkeeping and configuration
   logic [CW-1:0] cap_ff;
   logic [AW-1:0] cap_last_ff;
   logic [IW-1:0] ch_last_ff;
   logic [AW-1:0] wr_ptr_ff;
   logic [CW-1:0] fill_ff;
   logic [AW-1:0] cursor_ff;
   logic [CW-1:0] left_ff;

   // Scan and merge sequencing
   logic [AW-1:0] scan_addr_ff;
   logic [CW-1:0] scan_cnt_ff;
   logic          acc_en_ff;
   logic          acc_first_ff;
   logic [IW-1:0] ch_idx_ff;

   // Result beat
   logic                               rsp_strobe_ff;
   logic [trsm_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [trsm_pkg::CHAN_W-1:0]        rsp_channel_ff;
   logic signed [trsm_pkg::FIELD_W-1:0] rsp_low_ff;
   logic signed [trsm_pkg::FIELD_W-1:0] rsp_high_ff;
   logic [trsm_pkg::FIELD_W-1:0]       rsp_stamp_ff;
   logic [trsm_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic                               rsp_last_ff;

   // Timestamp memory
   logic [trsm_pkg::FIELD_W-1:0] stamp_mem_ff [MAX_DEPTH];
   logic [trsm_pkg::FIELD_W-1:0] stamp_rd_ff;

   logic                    accept;
   logic                    push_go;
   logic                    rd_go;
   logic [XW-1:0]           old_sum;
   logic [AW-1:0]           oldest;
   logic [AW-1:0]           wr_ptr_next;
   logic [AW-1:0]           cursor_next;
   logic [AW-1:0]           scan_next;
   logic [CW-1:0]           cap_in;
   logic [AW-1:0]           cap_last_in;
   logic [IW-1:0]           ch_last_in;
   logic [AW-1:0]           lane_rd_addr;
   trsm_pkg::lane_ctrl_type lane_ctrl;

   logic signed [trsm_pkg::FIELD_W-1:0] req_vals [4];
   logic signed [VALUE_BITS-1:0]        lane_rd   [MAX_CHANNELS];
   logic signed [VALUE_BITS-1:0]        lane_lo   [MAX_CHANNELS];
   logic signed [VALUE_BITS-1:0]        lane_hi   [MAX_CHANNELS];

   assign req_vals[0] = req_value_0;
   assign req_vals[1] = req_value_1;
   assign req_vals[2] = req_value_2;
   assign req_vals[3] = req_value_3;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && (state_ff == ST_IDLE);
   assign push_go = accept && (req_command == trsm_pkg::CMD_PUSH);
   assign rd_go   = accept && (req_command == trsm_pkg::CMD_RD_NEXT);

   // Oldest slot: write pointer minus fill, wrapped by capacity
   always_comb begin
      old_sum = XW'(wr_ptr_ff) + XW'(cap_ff) - XW'(fill_ff);
      if (old_sum >= XW'(cap_ff)) begin
         oldest = AW'(old_sum - XW'(cap_ff));
      end else begin
         oldest = AW'(old_sum);
      end
   end

   // Wrapping increments within the ring
   assign wr_ptr_next = (wr_ptr_ff == cap_last_ff) ? '0 : wr_ptr_ff + AW'(1);
   assign cursor_next = (cursor_ff == cap_last_ff) ? '0 : cursor_ff + AW'(1);
   assign scan_next   = (scan_addr_ff == cap_last_ff) ? '0 : scan_addr_ff + AW'(1);

   // Clamp register writes into their working ranges
   always_comb begin
      if (csr_data == '0) begin
         cap_in = CW'(1);
      end else if (32'(csr_data) > 32'(MAX_DEPTH)) begin
         cap_in = CW'(MAX_DEPTH);
      end else begin
         cap_in = CW'(csr_data);
      end
      cap_last_in = AW'(cap_in - CW'(1));
      if (csr_data[2:0] == 3'd0) begin
         ch_last_in = '0;
      end else if (32'(csr_data[2:0]) > 32'(MAX_CHANNELS)) begin
         ch_last_in = IW'(MAX_CHANNELS - 1);
      end else begin
         ch_last_in = IW'(csr_data[2:0] - 3'd1);
      end
   end

   // Lane controls
   assign lane_rd_addr        = (state_ff == ST_SCAN) ? scan_addr_ff : cursor_ff;
   assign lane_ctrl.wr_en     = push_go;
   assign lane_ctrl.rd_en     = (state_ff == ST_SCAN) || rd_go;
   assign lane_ctrl.acc_en    = acc_en_ff;
   assign lane_ctrl.acc_first = acc_first_ff;

   // One lane per channel
   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      trsm_lane #(
         .DEPTH      (MAX_DEPTH),
         .AW         (AW),
         .VALUE_BITS (VALUE_BITS)
      ) u_lane (
         .clock      (clock),
         .ctrl       (lane_ctrl),
         .wr_addr    (wr_ptr_ff),
         .wr_value   (VALUE_BITS'(req_vals[g % 4])),
         .rd_addr    (lane_rd_addr),
         .rd_value   (lane_rd[g]),
         .low_value  (lane_lo[g]),
         .high_value (lane_hi[g])
      );
   end

   // Timestamp store
   always_ff @(posedge clock) begin
      if (push_go) begin
         stamp_mem_ff[wr_ptr_ff] <= req_sample_time;
      end
      if (rd_go) begin
         stamp_rd_ff <= stamp_mem_ff[cursor_ff];
      end
   end

   // Sequencer, ring bookkeeping and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CW'(CAP_RESET);
         cap_last_ff   <= AW'(CAP_RESET - 1);
         ch_last_ff    <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         cursor_ff     <= '0;
         left_ff       <= '0;
         scan_addr_ff  <= '0;
         scan_cnt_ff   <= '0;
         acc_en_ff     <= 1'b0;
         acc_first_ff  <= 1'b0;
         ch_idx_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         acc_en_ff     <= (state_ff == ST_SCAN);
         acc_first_ff  <= (state_ff == ST_SCAN) && (scan_cnt_ff == '0);

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  unique case (req_command)
                     trsm_pkg::CMD_PUSH: begin
                        if (left_ff != '0) begin
                           if (left_ff >= cap_ff) begin
                              cursor_ff <= cursor_next;
                           end else begin
                              left_ff <= left_ff + CW'(1);
                           end
                        end
                        wr_ptr_ff <= wr_ptr_next;
                        if (fill_ff < cap_ff) begin
                           fill_ff <= fill_ff + CW'(1);
                        end
                     end
                     trsm_pkg::CMD_MINMAX: begin
                        if (fill_ff == '0) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= trsm_pkg::STS_EMPTY;
                           rsp_channel_ff <= '0;
                           rsp_low_ff    <= '0;
                           rsp_high_ff   <= '0;
                           rsp_stamp_ff  <= '0;
                           rsp_count_ff  <= trsm_pkg::COUNT_W'(fill_ff);
                           rsp_last_ff   <= 1'b1;
                        end else begin
                           scan_addr_ff <= oldest;
                           scan_cnt_ff  <= '0;
                           state_ff     <= ST_SCAN;
                        end
                     end
                     trsm_pkg::CMD_CLEAR: begin
                        wr_ptr_ff <= '0;
                        fill_ff   <= '0;
                        cursor_ff <= '0;
                        left_ff   <= '0;
                     end
                     trsm_pkg::CMD_RD_START: begin
                        rsp_strobe_ff  <= 1'b1;
                        rsp_channel_ff <= '0;
                        rsp_low_ff     <= '0;
                        rsp_high_ff    <= '0;
                        rsp_stamp_ff   <= '0;
                        rsp_count_ff   <= trsm_pkg::COUNT_W'(fill_ff);
                        rsp_last_ff    <= 1'b1;
                        if (fill_ff == '0) begin
                           left_ff       <= '0;
                           rsp_status_ff <= trsm_pkg::STS_EMPTY;
                        end else begin
                           cursor_ff     <= oldest;
                           left_ff       <= fill_ff;
                           rsp_status_ff <= trsm_pkg::STS_OK;
                        end
                     end
                     trsm_pkg::CMD_RD_NEXT: begin
                        if (left_ff == '0) begin
                           rsp_strobe_ff  <= 1'b1;
                           rsp_status_ff  <= trsm_pkg::STS_DONE;
                           rsp_channel_ff <= '0;
                           rsp_low_ff     <= '0;
                           rsp_high_ff    <= '0;
                           rsp_stamp_ff   <= '0;
                           rsp_count_ff   <= trsm_pkg::COUNT_W'(fill_ff);
                           rsp_last_ff    <= 1'b1;
                        end else begin
                           cursor_ff <= cursor_next;
                           left_ff   <= left_ff - CW'(1);
                           ch_idx_ff <= '0;
                           state_ff  <= ST_RD_OUT;
                        end
                     end
                     trsm_pkg::CMD_COUNT: begin
                        rsp_strobe_ff  <= 1'b1;
                        rsp_status_ff  <= trsm_pkg::STS_OK;
                        rsp_channel_ff <= '0;
                        rsp_low_ff     <= '0;
                        rsp_high_ff    <= '0;
                        rsp_stamp_ff   <= '0;
                        rsp_count_ff   <= trsm_pkg::COUNT_W'(fill_ff);
                        rsp_last_ff    <= 1'b1;
                     end
                     default: begin
                        // drop unknown commands
                     end
                  endcase
               end
            end

            // Walk the stored entries, oldest first, one a cycle
            ST_SCAN: begin
               scan_addr_ff <= scan_next;
               scan_cnt_ff  <= scan_cnt_ff + CW'(1);
               if (scan_cnt_ff + CW'(1) == fill_ff) begin
                  state_ff <= ST_WAIT;
               end
            end

            // Let the last read beat reach the accumulators
            ST_WAIT: begin
               ch_idx_ff <= '0;
               state_ff  <= ST_MM_OUT;
            end

            // Merge: one minmax beat per channel
            ST_MM_OUT: begin
               rsp_strobe_ff  <= 1'b1;
               rsp_status_ff  <= trsm_pkg::STS_OK;
               rsp_channel_ff <= trsm_pkg::CHAN_W'(ch_idx_ff);
               rsp_low_ff     <= trsm_pkg::FIELD_W'(lane_lo[ch_idx_ff]);
               rsp_high_ff    <= trsm_pkg::FIELD_W'(lane_hi[ch_idx_ff]);
               rsp_stamp_ff   <= '0;
               rsp_count_ff   <= trsm_pkg::COUNT_W'(fill_ff);
               rsp_last_ff    <= (ch_idx_ff == ch_last_ff);
               if (ch_idx_ff == ch_last_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ch_idx_ff <= ch_idx_ff + IW'(1);
               end
            end

            // Readout: one sample beat per channel
            ST_RD_OUT: begin
               rsp_strobe_ff  <= 1'b1;
               rsp_status_ff  <= trsm_pkg::STS_OK;
               rsp_channel_ff <= trsm_pkg::CHAN_W'(ch_idx_ff);
               rsp_low_ff     <= trsm_pkg::FIELD_W'(lane_rd[ch_idx_ff]);
               rsp_high_ff    <= '0;
               rsp_stamp_ff   <= stamp_rd_ff;
               rsp_count_ff   <= trsm_pkg::COUNT_W'(fill_ff);
               rsp_last_ff    <= (ch_idx_ff == ch_last_ff);
               if (ch_idx_ff == ch_last_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ch_idx_ff <= ch_idx_ff + IW'(1);
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // Register writes take effect and empty the ring
         if (csr_write) begin
            if (csr_index == trsm_pkg::CSR_CAPACITY) begin
               cap_ff      <= cap_in;
               cap_last_ff <= cap_last_in;
            end
            if (csr_index == trsm_pkg::CSR_CHANNELS) begin
               ch_last_ff <= ch_last_in;
            end
            if (csr_index == trsm_pkg::CSR_CAPACITY ||
                csr_index == trsm_pkg::CSR_CHANNELS) begin
               wr_ptr_ff <= '0;
               fill_ff   <= '0;
               cursor_ff <= '0;
               left_ff   <= '0;
            end
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_low_value    = rsp_low_ff;
   assign rsp_high_value   = rsp_high_ff;
   assign rsp_stamp        = rsp_stamp_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

`default_nettype wire
